/* design/rrq_pkg.sv */
`timescale 1ns / 1ps

package rrq_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ELEM_W   = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_REMOVED = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ELEM_W-1:0] elem_in;
  } req_item_t;

  typedef struct packed {
    logic [ELEM_W-1:0]   elem_out;
    logic                has_elem;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count_out;
  } rsp_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADD1,
    ST_ADD2,
    ST_ADD3,
    ST_RM1,
    ST_RM2,
    ST_RM3,
    ST_GN2,
    ST_GN3,
    ST_GN_OUT
  } state_t;

  // Read address sources for both memories.
  typedef enum logic {
    RSEL_BC,
    RSEL_LINK
  } rsel_t;

  typedef enum logic {
    WADDR_SLOT,
    WADDR_BC
  } waddr_sel_t;

  typedef enum logic {
    WDATA_SLOT,
    WDATA_LINK
  } wdata_sel_t;

  typedef enum logic [1:0] {
    USED_HOLD,
    USED_SET_SLOT,
    USED_CLR_BC,
    USED_CLR_CUR
  } used_op_t;

  typedef enum logic [1:0] {
    BC_HOLD,
    BC_SLOT,
    BC_LINK,
    BC_ZERO
  } bc_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    JR_HOLD,
    JR_SET,
    JR_CLR
  } jr_op_t;

  typedef struct packed {
    logic       latch_in;
    logic       latch_slot;
    logic       latch_cur;
    rsel_t      nl_rsel;
    rsel_t      es_rsel;
    logic       nl_we;
    waddr_sel_t nl_waddr_sel;
    wdata_sel_t nl_wdata_sel;
    logic       es_we;
    used_op_t   used_op;
    bc_op_t     bc_op;
    cnt_op_t    cnt_op;
    jr_op_t     jr_op;
    logic       out_load;
    status_t    res_status;
    logic       res_elem;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             cnt_zero;
    logic             cnt_one;
    logic             full;
    logic             jr;
    logic             out_hold;
  } dp_status_t;

endpackage

/* design/rrq_ctrl.sv */
`timescale 1ns / 1ps

module rrq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rrq_pkg::dp_status_t stat,
  output rrq_pkg::ctrl_cmd_t  ctl
);

  rrq_pkg::state_t state;
  rrq_pkg::state_t state_next;

  assign req_stall = (state != rrq_pkg::ST_IDLE) || stat.out_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rrq_pkg::ST_IDLE: begin
        if (req_valid && !req_stall) begin
          state_next = rrq_pkg::ST_EXEC;
        end
      end
      rrq_pkg::ST_EXEC: begin
        state_next = rrq_pkg::ST_IDLE;
        unique case (stat.cmd)
          rrq_pkg::CMD_ADD: begin
            if (!stat.full) begin
              state_next = stat.cnt_zero ? rrq_pkg::ST_ADD1 : rrq_pkg::ST_ADD2;
            end
          end
          rrq_pkg::CMD_REMOVE: begin
            if (!stat.cnt_zero && !stat.jr) begin
              state_next = stat.cnt_one ? rrq_pkg::ST_RM1 : rrq_pkg::ST_RM2;
            end
          end
          rrq_pkg::CMD_NEXT: begin
            if (!stat.cnt_zero) begin
              state_next = rrq_pkg::ST_GN2;
            end
          end
          default: begin
            state_next = rrq_pkg::ST_IDLE;
          end
        endcase
      end
      rrq_pkg::ST_ADD1:   state_next = rrq_pkg::ST_IDLE;
      rrq_pkg::ST_ADD2:   state_next = rrq_pkg::ST_ADD3;
      rrq_pkg::ST_ADD3:   state_next = rrq_pkg::ST_IDLE;
      rrq_pkg::ST_RM1:    state_next = rrq_pkg::ST_IDLE;
      rrq_pkg::ST_RM2:    state_next = rrq_pkg::ST_RM3;
      rrq_pkg::ST_RM3:    state_next = rrq_pkg::ST_IDLE;
      rrq_pkg::ST_GN2: begin
        state_next = stat.jr ? rrq_pkg::ST_GN_OUT : rrq_pkg::ST_GN3;
      end
      rrq_pkg::ST_GN3:    state_next = rrq_pkg::ST_GN_OUT;
      rrq_pkg::ST_GN_OUT: state_next = rrq_pkg::ST_IDLE;
      default:            state_next = rrq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl              = '0;
    ctl.nl_rsel      = rrq_pkg::RSEL_BC;
    ctl.es_rsel      = rrq_pkg::RSEL_BC;
    ctl.nl_waddr_sel = rrq_pkg::WADDR_SLOT;
    ctl.nl_wdata_sel = rrq_pkg::WDATA_SLOT;
    ctl.used_op      = rrq_pkg::USED_HOLD;
    ctl.bc_op        = rrq_pkg::BC_HOLD;
    ctl.cnt_op       = rrq_pkg::CNT_HOLD;
    ctl.jr_op        = rrq_pkg::JR_HOLD;
    ctl.res_status   = rrq_pkg::STATUS_OK;
    unique case (state)
      rrq_pkg::ST_IDLE: begin
        ctl.latch_in = req_valid && !req_stall;
      end
      rrq_pkg::ST_EXEC: begin
        unique case (stat.cmd)
          rrq_pkg::CMD_ADD: begin
            if (stat.full) begin
              ctl.out_load   = 1'b1;
              ctl.res_status = rrq_pkg::STATUS_FULL;
            end else begin
              // The link of the slot before current is read for the splice.
              ctl.latch_slot = 1'b1;
              ctl.nl_rsel    = rrq_pkg::RSEL_BC;
            end
          end
          rrq_pkg::CMD_REMOVE: begin
            if (stat.cnt_zero) begin
              ctl.out_load   = 1'b1;
              ctl.res_status = rrq_pkg::STATUS_EMPTY;
            end else if (stat.jr) begin
              ctl.out_load   = 1'b1;
              ctl.res_status = rrq_pkg::STATUS_REMOVED;
            end else begin
              ctl.nl_rsel = rrq_pkg::RSEL_BC;
              ctl.es_rsel = rrq_pkg::RSEL_BC;
            end
          end
          rrq_pkg::CMD_NEXT: begin
            if (stat.cnt_zero) begin
              ctl.out_load   = 1'b1;
              ctl.res_status = rrq_pkg::STATUS_EMPTY;
            end else begin
              ctl.nl_rsel = rrq_pkg::RSEL_BC;
            end
          end
          default: begin
            ctl.out_load = 1'b1;
          end
        endcase
      end
      rrq_pkg::ST_ADD1: begin
        ctl.nl_we        = 1'b1;
        ctl.nl_waddr_sel = rrq_pkg::WADDR_SLOT;
        ctl.nl_wdata_sel = rrq_pkg::WDATA_SLOT;
        ctl.es_we        = 1'b1;
        ctl.used_op      = rrq_pkg::USED_SET_SLOT;
        ctl.bc_op        = rrq_pkg::BC_SLOT;
        ctl.cnt_op       = rrq_pkg::CNT_INC;
        ctl.jr_op        = rrq_pkg::JR_CLR;
        ctl.out_load     = 1'b1;
      end
      rrq_pkg::ST_ADD2: begin
        ctl.nl_we        = 1'b1;
        ctl.nl_waddr_sel = rrq_pkg::WADDR_SLOT;
        ctl.nl_wdata_sel = rrq_pkg::WDATA_LINK;
        ctl.es_we        = 1'b1;
        ctl.used_op      = rrq_pkg::USED_SET_SLOT;
      end
      rrq_pkg::ST_ADD3: begin
        ctl.nl_we        = 1'b1;
        ctl.nl_waddr_sel = rrq_pkg::WADDR_BC;
        ctl.nl_wdata_sel = rrq_pkg::WDATA_SLOT;
        ctl.bc_op        = rrq_pkg::BC_SLOT;
        ctl.cnt_op       = rrq_pkg::CNT_INC;
        ctl.jr_op        = rrq_pkg::JR_CLR;
        ctl.out_load     = 1'b1;
      end
      rrq_pkg::ST_RM1: begin
        ctl.used_op  = rrq_pkg::USED_CLR_BC;
        ctl.bc_op    = rrq_pkg::BC_ZERO;
        ctl.cnt_op   = rrq_pkg::CNT_DEC;
        ctl.jr_op    = rrq_pkg::JR_SET;
        ctl.out_load = 1'b1;
        ctl.res_elem = 1'b1;
      end
      rrq_pkg::ST_RM2: begin
        ctl.latch_cur = 1'b1;
        ctl.nl_rsel   = rrq_pkg::RSEL_LINK;
        ctl.es_rsel   = rrq_pkg::RSEL_LINK;
      end
      rrq_pkg::ST_RM3: begin
        ctl.nl_we        = 1'b1;
        ctl.nl_waddr_sel = rrq_pkg::WADDR_BC;
        ctl.nl_wdata_sel = rrq_pkg::WDATA_LINK;
        ctl.used_op      = rrq_pkg::USED_CLR_CUR;
        ctl.cnt_op       = rrq_pkg::CNT_DEC;
        ctl.jr_op        = rrq_pkg::JR_SET;
        ctl.out_load     = 1'b1;
        ctl.res_elem     = 1'b1;
      end
      rrq_pkg::ST_GN2: begin
        ctl.es_rsel = rrq_pkg::RSEL_LINK;
        if (!stat.jr) begin
          ctl.bc_op   = rrq_pkg::BC_LINK;
          ctl.nl_rsel = rrq_pkg::RSEL_LINK;
        end
      end
      rrq_pkg::ST_GN3: begin
        ctl.es_rsel = rrq_pkg::RSEL_LINK;
      end
      rrq_pkg::ST_GN_OUT: begin
        ctl.jr_op    = rrq_pkg::JR_CLR;
        ctl.out_load = 1'b1;
        ctl.res_elem = 1'b1;
      end
      default: begin
        ctl.latch_in = 1'b0;
      end
    endcase
  end

endmodule

/* design/rrq_dpath.sv */
`timescale 1ns / 1ps

module rrq_dpath (
  input  logic                clk,
  input  logic                rst,
  input  rrq_pkg::req_item_t  req,
  output rrq_pkg::rsp_item_t  rsp,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  rrq_pkg::ctrl_cmd_t  ctl,
  output rrq_pkg::dp_status_t stat
);

  logic [rrq_pkg::IDX_W-1:0]  next_link [rrq_pkg::DEPTH];
  logic [rrq_pkg::ELEM_W-1:0] elem_store [rrq_pkg::DEPTH];

  logic [rrq_pkg::CMD_W-1:0]  cmd_q;
  logic [rrq_pkg::ELEM_W-1:0] elem_q;
  logic [rrq_pkg::IDX_W-1:0]  slot;
  logic [rrq_pkg::IDX_W-1:0]  cur;
  logic [rrq_pkg::IDX_W-1:0]  before_current;
  logic [rrq_pkg::CNT_W-1:0]  count;
  logic [rrq_pkg::CNT_W-1:0]  count_next;
  logic                       just_removed;
  logic [rrq_pkg::DEPTH-1:0]  slot_used;

  logic [rrq_pkg::IDX_W-1:0]  link_rd;
  logic [rrq_pkg::ELEM_W-1:0] elem_rd;
  logic [rrq_pkg::IDX_W-1:0]  nl_raddr;
  logic [rrq_pkg::IDX_W-1:0]  es_raddr;
  logic [rrq_pkg::IDX_W-1:0]  nl_waddr;
  logic [rrq_pkg::IDX_W-1:0]  nl_wdata;
  logic [rrq_pkg::IDX_W-1:0]  free_slot;

  // Lowest-numbered slot that is not in use.
  always_comb begin
    free_slot = '0;
    for (int i = rrq_pkg::DEPTH - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_slot = rrq_pkg::IDX_W'(i);
      end
    end
  end

  assign nl_raddr = (ctl.nl_rsel == rrq_pkg::RSEL_LINK) ? link_rd : before_current;
  assign es_raddr = (ctl.es_rsel == rrq_pkg::RSEL_LINK) ? link_rd : before_current;
  assign nl_waddr = (ctl.nl_waddr_sel == rrq_pkg::WADDR_BC) ? before_current : slot;
  assign nl_wdata = (ctl.nl_wdata_sel == rrq_pkg::WDATA_LINK) ? link_rd : slot;

  always_ff @(posedge clk) begin
    if (ctl.nl_we) begin
      next_link[nl_waddr] <= nl_wdata;
    end
    link_rd <= next_link[nl_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.es_we) begin
      elem_store[slot] <= elem_q;
    end
    elem_rd <= elem_store[es_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_q  <= req.cmd;
      elem_q <= req.elem_in;
    end
    if (ctl.latch_slot) begin
      slot <= free_slot;
    end
    if (ctl.latch_cur) begin
      cur <= link_rd;
    end
  end

  always_comb begin
    unique case (ctl.cnt_op)
      rrq_pkg::CNT_INC: count_next = count + 1'b1;
      rrq_pkg::CNT_DEC: count_next = count - 1'b1;
      default:          count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      before_current <= '0;
      count          <= '0;
      just_removed   <= 1'b0;
      slot_used      <= '0;
    end else begin
      count <= count_next;
      unique case (ctl.bc_op)
        rrq_pkg::BC_SLOT: before_current <= slot;
        rrq_pkg::BC_LINK: before_current <= link_rd;
        rrq_pkg::BC_ZERO: before_current <= '0;
        default:          before_current <= before_current;
      endcase
      unique case (ctl.jr_op)
        rrq_pkg::JR_SET: just_removed <= 1'b1;
        rrq_pkg::JR_CLR: just_removed <= 1'b0;
        default:         just_removed <= just_removed;
      endcase
      unique case (ctl.used_op)
        rrq_pkg::USED_SET_SLOT: slot_used[slot]           <= 1'b1;
        rrq_pkg::USED_CLR_BC:   slot_used[before_current] <= 1'b0;
        rrq_pkg::USED_CLR_CUR:  slot_used[cur]            <= 1'b0;
        default:                slot_used                 <= slot_used;
      endcase
    end
  end

  // Output register; a held result keeps its payload until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp.elem_out  <= ctl.res_elem ? elem_rd : '0;
      rsp.has_elem  <= ctl.res_elem;
      rsp.status    <= ctl.res_status;
      rsp.count_out <= count_next;
    end
  end

  assign stat.cmd      = cmd_q;
  assign stat.cnt_zero = (count == '0);
  assign stat.cnt_one  = (count == rrq_pkg::CNT_W'(1));
  assign stat.full     = (count >= rrq_pkg::CNT_W'(rrq_pkg::DEPTH));
  assign stat.jr       = just_removed;
  assign stat.out_hold = rsp_valid && rsp_stall;

endmodule

/* design/round_robin_ring_queue_top.sv */
// Round-robin ring of element IDs. Each request is add, remove-current or
// get-next, and each gives exactly one response with the element (if any), a
// status code and the element count after the step. Requests are handled one
// at a time: refusals (full, empty, already removed) and unused commands are
// answered from the execute state; add to an empty ring takes ADD1, removing
// the last element RM1, other adds ADD2 and ADD3, other removes RM2 and RM3,
// and get-next GN2, GN3 (skipped right after a removal) and GN_OUT, as the
// link and element memories each have one registered read port, through
// which the chain of link lookups is walked one read per cycle. A response
// waiting in the output register stalls new requests until taken.
`timescale 1ns / 1ps

module round_robin_ring_queue_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  rrq_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rrq_pkg::rsp_item_t rsp
);

  rrq_pkg::ctrl_cmd_t  ctl;
  rrq_pkg::dp_status_t stat;

  rrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  rrq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule

/* design/rrq_checker.sv */
`timescale 1ns / 1ps

module rrq_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input rrq_pkg::req_item_t req,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input rrq_pkg::rsp_item_t rsp
);

  // A stalled request stays and keeps its payload until taken.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

  // A stalled response stays and keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // One request at a time: an accepted request blocks the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while previous one in progress");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.has_elem |-> rsp.elem_out == '0)
    else $error("element reported without has_elem");

  // A full refusal can only happen with the ring at capacity, and carries no element.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == rrq_pkg::STATUS_FULL |->
      rsp.count_out == rrq_pkg::CNT_W'(rrq_pkg::DEPTH) && !rsp.has_elem)
    else $error("full status with ring not full");

endmodule

bind round_robin_ring_queue_top rrq_checker u_rrq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
